// ===== design/glzw_pkg.sv =====
// ----------------------------------------------------------------------------
// glzw_pkg: shared types and constants
// Item types, dictionary entry layout and the back-end state encoding of the
// GIF LZW encoder.
// ----------------------------------------------------------------------------
package glzw_pkg;

  localparam int CODE_W  = 12;  // widest LZW code
  localparam int SYM_W   = 8;   // pixel color index
  localparam int CW_W    = 4;   // code width field
  localparam int NFC_W   = 13;  // next free code counter
  localparam int TAG_W   = 4;   // dictionary epoch tag
  localparam int BUF_W   = 19;  // packer bit buffer: 7 held bits plus one code
  localparam int FILL_W  = 5;   // packer fill count
  localparam int MCS_W   = 4;   // minimum code size register

  localparam logic [TAG_W-1:0] TAG_EMPTY = '0;
  localparam logic [TAG_W-1:0] TAG_FIRST = TAG_W'(1);
  localparam logic [TAG_W-1:0] TAG_LAST  = '1;
  localparam logic [MCS_W-1:0] MCS_RESET = MCS_W'(8);
  localparam logic [MCS_W-1:0] MCS_MIN   = MCS_W'(2);
  localparam logic [MCS_W-1:0] MCS_MAX   = MCS_W'(8);

  typedef struct packed {
    logic [7:0] pixel_index;
    logic       last_pixel;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       final_byte;
  } out_item_t;

  // pixel after classification by the front end
  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             last;
    logic             first;
  } px_item_t;

  // one code for the bit packer
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [CW_W-1:0]   width;
    logic              last;
  } code_item_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [CODE_W-1:0] prefix;
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] code;
  } dict_entry_t;

  typedef enum logic [2:0] {
    BK_SWEEP,
    BK_WAIT,
    BK_CMP,
    BK_EMIT_MISS,
    BK_EMIT_FULL,
    BK_EMIT_FIRST,
    BK_EMIT_TAIL,
    BK_EMIT_EOI
  } back_state_t;

endpackage

// ===== design/gif_lzw_encoder.sv =====
// ----------------------------------------------------------------------------
// gif_lzw_encoder: GIF variable-width LZW compressor
// Pixel color indices in, packed LZW code stream bytes out.
// ----------------------------------------------------------------------------
// Pixels enter through a queue port (push/full) and compressed bytes leave
// through a queue port (empty/pop), LSB first, with final_byte set on the last
// byte of each image. A front end masks each pixel to the code size and marks
// the first pixel of an image; a two-entry queue decouples it from the
// dictionary engine, which probes a hashed dictionary RAM of DICT_ENTRIES
// slots with linear probing. For each pixel the engine issues the probe read,
// compares, advances the probe on each collision and, on a miss, hands the
// prefix code to the packer; each extra code (clear, end-of-information) has
// its own state. The packer drains one byte per cycle into a four-entry result
// queue while that queue has room. Dictionary clears (table full, end of
// image, write to cfg) retire old entries by epoch tag; on every fifteenth
// clear, and once after reset, a sweep of all DICT_ENTRIES slots wipes the
// RAM, during which pixels queue but are not processed. The user must make a
// cfg write only while idle; the block does not enforce this. A cfg write sets
// the minimum code size (clamped to 2..8) and restarts the encoder.
// ----------------------------------------------------------------------------
module gif_lzw_encoder #(
  parameter int DICT_ENTRIES  = 4096,
  parameter int MAX_CODE_BITS = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // pixel requests
  input  logic                       push,
  output logic                       full,
  input  glzw_pkg::in_item_t         in_data,
  // byte requests
  output logic                       empty,
  input  logic                       pop,
  output glzw_pkg::out_item_t        out_data,
  // minimum code size register
  input  logic                       cfg_we,
  input  logic [glzw_pkg::MCS_W-1:0] cfg_wdata
);
  import glzw_pkg::*;

  logic [MCS_W-1:0] mcs_r, mcs_nxt;
  logic [MCS_W-1:0] cfg_mcs;
  px_item_t         q_item;
  logic             q_empty, q_pop;
  logic             code_valid, code_ready;
  code_item_t       code_item;

  // clamp out-of-range sizes
  always_comb begin
    if (cfg_wdata < MCS_MIN) begin
      cfg_mcs = MCS_MIN;
    end else if (cfg_wdata > MCS_MAX) begin
      cfg_mcs = MCS_MAX;
    end else begin
      cfg_mcs = cfg_wdata;
    end
    mcs_nxt = cfg_we ? cfg_mcs : mcs_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mcs_r <= MCS_RESET;
    end else begin
      mcs_r <= mcs_nxt;
    end
  end

  // classify and queue pixels
  glzw_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_we),
    .mcs     (mcs_r),
    .push    (push),
    .in_data (in_data),
    .full    (full),
    .q_pop   (q_pop),
    .q_item  (q_item),
    .q_empty (q_empty)
  );

  // dictionary lookup and code generation
  glzw_back #(
    .DICT_ENTRIES  (DICT_ENTRIES),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_mcs    (cfg_mcs),
    .mcs        (mcs_r),
    .q_item     (q_item),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .code_valid (code_valid),
    .code_ready (code_ready),
    .code_item  (code_item)
  );

  // pack codes into bytes and hold them for the consumer
  glzw_packer u_packer (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .code_valid (code_valid),
    .code_ready (code_ready),
    .code_item  (code_item),
    .empty      (empty),
    .pop        (pop),
    .out_data   (out_data)
  );

endmodule

// ===== design/glzw_ram.sv =====
// ----------------------------------------------------------------------------
// glzw_ram: generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module glzw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/glzw_fifo.sv =====
// ----------------------------------------------------------------------------
// glzw_fifo: small register queue
// Power-of-two depth, head shown combinationally, synchronous flush.
// ----------------------------------------------------------------------------
module glzw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             flush,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [PW:0]      cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == (PW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (flush) begin
      wptr_nxt = '0;
      rptr_nxt = '0;
      cnt_nxt  = '0;
    end else begin
      if (do_push) wptr_nxt = wptr_r + PW'(1);
      if (do_pop)  rptr_nxt = rptr_r + PW'(1);
      if (do_push && !do_pop) cnt_nxt = cnt_r + (PW+1)'(1);
      if (do_pop && !do_push) cnt_nxt = cnt_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push && !flush) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

// ===== design/glzw_front.sv =====
// ----------------------------------------------------------------------------
// glzw_front: pixel intake
// Accept pixels, mask the index to the code size, tag the first pixel of an
// image and queue the result for the back end.
// ----------------------------------------------------------------------------
module glzw_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [glzw_pkg::MCS_W-1:0]     mcs,
  input  logic                           push,
  input  glzw_pkg::in_item_t             in_data,
  output logic                           full,
  input  logic                           q_pop,
  output glzw_pkg::px_item_t             q_item,
  output logic                           q_empty
);
  import glzw_pkg::*;

  logic             started_r, started_nxt;
  logic             accept;
  logic [SYM_W-1:0] sym_mask;
  px_item_t         px;
  logic [$bits(px_item_t)-1:0] q_raw;

  assign accept   = push && !full;
  assign sym_mask = SYM_W'((9'(1) << mcs) - 9'(1));

  always_comb begin
    px.sym   = in_data.pixel_index & sym_mask;
    px.last  = in_data.last_pixel;
    px.first = !started_r;
    started_nxt = started_r;
    if (cfg_we) begin
      started_nxt = 1'b0;
    end else if (accept) begin
      started_nxt = !in_data.last_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
    end else begin
      started_r <= started_nxt;
    end
  end

  glzw_fifo #(
    .WIDTH ($bits(px_item_t)),
    .DEPTH (2)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .flush (cfg_we),
    .push  (push),
    .wdata (px),
    .pop   (q_pop),
    .rdata (q_raw),
    .full  (full),
    .empty (q_empty)
  );

  assign q_item = px_item_t'(q_raw);

endmodule

// ===== design/glzw_back.sv =====
// ----------------------------------------------------------------------------
// glzw_back: dictionary engine
// Probe the hashed dictionary, add entries on a miss, track code width and
// issue codes to the packer. Stale entries are retired by epoch tag.
// ----------------------------------------------------------------------------
module glzw_back #(
  parameter int DICT_ENTRIES  = 4096,
  parameter int MAX_CODE_BITS = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [glzw_pkg::MCS_W-1:0] cfg_mcs,
  input  logic [glzw_pkg::MCS_W-1:0] mcs,
  input  glzw_pkg::px_item_t         q_item,
  input  logic                       q_empty,
  output logic                       q_pop,
  output logic                       code_valid,
  input  logic                       code_ready,
  output glzw_pkg::code_item_t       code_item
);
  import glzw_pkg::*;

  localparam int AW         = $clog2(DICT_ENTRIES);
  localparam int CODE_SPACE = 1 << MAX_CODE_BITS;
  localparam int DICT_LIMIT = (DICT_ENTRIES < CODE_SPACE) ? DICT_ENTRIES : CODE_SPACE;

  back_state_t       state_r, state_nxt;
  back_state_t       ret_r, ret_nxt;
  logic [CODE_W-1:0] prefix_r, prefix_nxt;
  logic [SYM_W-1:0]  sym_r, sym_nxt;
  logic              last_r, last_nxt;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic [AW-1:0]     sweep_r, sweep_nxt;
  logic [NFC_W-1:0]  nf_r, nf_nxt;
  logic [CW_W-1:0]   cw_r, cw_nxt;
  logic [TAG_W-1:0]  epoch_r, epoch_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  dict_entry_t       ram_wdata, rd_entry;
  logic [$bits(dict_entry_t)-1:0] ram_rdata;

  logic [CODE_W-1:0] reset_code, end_code;
  logic [NFC_W-1:0]  nf_inc;
  logic [MCS_W-1:0]  clr_mcs;
  logic              do_clear;
  back_state_t       clr_ret;
  back_state_t       after_item;
  logic              hit, slot_free;

  assign rd_entry   = dict_entry_t'(ram_rdata);
  assign reset_code = CODE_W'(1) << mcs;
  assign end_code   = reset_code + CODE_W'(1);
  assign nf_inc     = nf_r + NFC_W'(1);
  assign after_item = last_r ? BK_EMIT_TAIL : BK_WAIT;
  assign slot_free  = (rd_entry.tag != epoch_r);
  assign hit        = !slot_free && (rd_entry.prefix == prefix_r) && (rd_entry.sym == sym_r);

  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    prefix_nxt = prefix_r;
    sym_nxt    = sym_r;
    last_nxt   = last_r;
    addr_nxt   = addr_r;
    sweep_nxt  = sweep_r;
    nf_nxt     = nf_r;
    cw_nxt     = cw_r;
    epoch_nxt  = epoch_r;
    q_pop      = 1'b0;
    code_valid = 1'b0;
    code_item  = '{code: prefix_r, width: cw_r, last: 1'b0};
    ram_we     = 1'b0;
    ram_waddr  = addr_r;
    ram_wdata  = '{tag: epoch_r, prefix: prefix_r, sym: sym_r, code: nf_r[CODE_W-1:0]};
    ram_raddr  = addr_r;
    do_clear   = 1'b0;
    clr_ret    = BK_WAIT;
    clr_mcs    = mcs;

    unique case (state_r)
      BK_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_r;
        ram_wdata = '{tag: TAG_EMPTY, prefix: '0, sym: '0, code: '0};
        sweep_nxt = sweep_r + AW'(1);
        if (sweep_r == '1) begin
          epoch_nxt = TAG_FIRST;
          state_nxt = ret_r;
        end
      end
      BK_WAIT: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          sym_nxt  = q_item.sym;
          last_nxt = q_item.last;
          if (q_item.first) begin
            prefix_nxt = CODE_W'(q_item.sym);
            state_nxt  = BK_EMIT_FIRST;
          end else begin
            ram_raddr = prefix_r[AW-1:0] ^ (AW'(q_item.sym) << (AW - SYM_W));
            addr_nxt  = ram_raddr;
            state_nxt = BK_CMP;
          end
        end
      end
      BK_CMP: begin
        if (hit) begin
          prefix_nxt = rd_entry.code;
          state_nxt  = after_item;
        end else if (slot_free) begin
          ram_we    = 1'b1;
          state_nxt = BK_EMIT_MISS;
        end else begin
          // advance linear probe
          ram_raddr = addr_r + AW'(1);
          addr_nxt  = ram_raddr;
        end
      end
      BK_EMIT_MISS: begin
        code_valid = 1'b1;
        if (code_ready) begin
          nf_nxt     = nf_inc;
          prefix_nxt = CODE_W'(sym_r);
          if (nf_inc >= NFC_W'(DICT_LIMIT)) begin
            state_nxt = BK_EMIT_FULL;
          end else begin
            if (nf_inc > (NFC_W'(1) << cw_r) && cw_r < CW_W'(MAX_CODE_BITS)) begin
              cw_nxt = cw_r + CW_W'(1);
            end
            state_nxt = after_item;
          end
        end
      end
      BK_EMIT_FULL: begin
        code_valid     = 1'b1;
        code_item.code = reset_code;
        if (code_ready) begin
          do_clear = 1'b1;
          clr_ret  = after_item;
        end
      end
      BK_EMIT_FIRST: begin
        code_valid     = 1'b1;
        code_item.code = reset_code;
        if (code_ready) begin
          state_nxt = after_item;
        end
      end
      BK_EMIT_TAIL: begin
        code_valid = 1'b1;
        if (code_ready) begin
          state_nxt = BK_EMIT_EOI;
        end
      end
      BK_EMIT_EOI: begin
        code_valid     = 1'b1;
        code_item.code = end_code;
        code_item.last = 1'b1;
        if (code_ready) begin
          do_clear = 1'b1;
          clr_ret  = BK_WAIT;
        end
      end
      default: begin
        state_nxt = BK_WAIT;
      end
    endcase

    if (cfg_we) begin
      clr_mcs = cfg_mcs;
      if (state_r == BK_SWEEP) begin
        nf_nxt = NFC_W'((CODE_W'(1) << cfg_mcs) + CODE_W'(2));
        cw_nxt = cfg_mcs + CW_W'(1);
      end else begin
        do_clear = 1'b1;
        clr_ret  = BK_WAIT;
      end
    end

    // fresh dictionary: bump epoch, or sweep once the tags run out
    if (do_clear) begin
      nf_nxt = NFC_W'((CODE_W'(1) << clr_mcs) + CODE_W'(2));
      cw_nxt = clr_mcs + CW_W'(1);
      if (epoch_r == TAG_LAST) begin
        state_nxt = BK_SWEEP;
        sweep_nxt = '0;
        ret_nxt   = clr_ret;
      end else begin
        epoch_nxt = epoch_r + TAG_W'(1);
        state_nxt = clr_ret;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_SWEEP;
      ret_r   <= BK_WAIT;
      sweep_r <= '0;
      epoch_r <= TAG_FIRST;
      nf_r    <= NFC_W'((CODE_W'(1) << MCS_RESET) + CODE_W'(2));
      cw_r    <= MCS_RESET + CW_W'(1);
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      sweep_r <= sweep_nxt;
      epoch_r <= epoch_nxt;
      nf_r    <= nf_nxt;
      cw_r    <= cw_nxt;
      last_r  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prefix_r <= prefix_nxt;
    sym_r    <= sym_nxt;
    addr_r   <= addr_nxt;
  end

  glzw_ram #(
    .WIDTH ($bits(dict_entry_t)),
    .DEPTH (DICT_ENTRIES)
  ) u_dict (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ===== design/glzw_packer.sv =====
// ----------------------------------------------------------------------------
// glzw_packer: LSB-first bit packer
// Append codes to a bit buffer, drain whole bytes into the result queue and
// pad the final byte of the stream.
// ----------------------------------------------------------------------------
module glzw_packer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 code_valid,
  output logic                 code_ready,
  input  glzw_pkg::code_item_t code_item,
  output logic                 empty,
  input  logic                 pop,
  output glzw_pkg::out_item_t  out_data
);
  import glzw_pkg::*;

  logic [BUF_W-1:0]  buf_r, buf_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              flush_r, flush_nxt;
  logic              drain, q_push, q_full;
  logic [CODE_W-1:0] code_m;
  out_item_t         byte_item;
  logic [$bits(out_item_t)-1:0] q_raw;

  assign drain      = (fill_r >= FILL_W'(8)) || (flush_r && fill_r != '0);
  assign q_push     = drain && !q_full;
  assign code_ready = !drain;
  assign code_m     = code_item.code & ~({CODE_W{1'b1}} << code_item.width);
  assign byte_item  = '{out_byte: buf_r[7:0], final_byte: flush_r && fill_r <= FILL_W'(8)};

  always_comb begin
    buf_nxt   = buf_r;
    fill_nxt  = fill_r;
    flush_nxt = flush_r;
    if (cfg_we) begin
      // drop buffered bits
      buf_nxt   = '0;
      fill_nxt  = '0;
      flush_nxt = 1'b0;
    end else if (q_push) begin
      buf_nxt = buf_r >> 8;
      if (fill_r >= FILL_W'(8)) begin
        fill_nxt = fill_r - FILL_W'(8);
      end else begin
        fill_nxt = '0;
      end
      if (flush_r && fill_r <= FILL_W'(8)) begin
        flush_nxt = 1'b0;
      end
    end else if (code_valid && code_ready) begin
      buf_nxt   = buf_r | (BUF_W'(code_m) << fill_r);
      fill_nxt  = fill_r + FILL_W'(code_item.width);
      flush_nxt = code_item.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r   <= '0;
      fill_r  <= '0;
      flush_r <= 1'b0;
    end else begin
      buf_r   <= buf_nxt;
      fill_r  <= fill_nxt;
      flush_r <= flush_nxt;
    end
  end

  glzw_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (4)
  ) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .flush (cfg_we),
    .push  (q_push),
    .wdata (byte_item),
    .pop   (pop),
    .rdata (q_raw),
    .full  (q_full),
    .empty (empty)
  );

  assign out_data = out_item_t'(q_raw);

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: GIF LZW encoder testbench
// Drives pixel requests through the queue port, predicts the packed byte
// stream with a behavioral LZW encoder and checks every byte as it is popped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import glzw_pkg::*;

  localparam int DICT_SIZE   = 4096;
  localparam int MAX_BITS    = 12;
  localparam int DICT_CAP    = (DICT_SIZE < (1 << MAX_BITS)) ? DICT_SIZE : (1 << MAX_BITS);
  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_WAIT  = 64;

  logic       clk;
  logic       rst_n;
  logic       push;
  logic       full;
  in_item_t   in_data;
  logic       empty;
  logic       pop;
  out_item_t  out_data;
  logic       cfg_we;
  logic [MCS_W-1:0] cfg_wdata;

  gif_lzw_encoder dut (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // Predictor state: a mirror of the encoder's dictionary and bit packer.
  logic        dict_used [DICT_SIZE];
  logic [11:0] dict_pfx  [DICT_SIZE];
  logic [7:0]  dict_sym  [DICT_SIZE];
  int unsigned free_code;
  int unsigned width_now;
  int unsigned pend_code;
  bit          img_open;
  logic [7:0]  pack_buf;
  int unsigned pack_fill;
  logic [3:0]  code_size_reg;
  out_item_t   byte_queue[$];
  int unsigned step_bytes;

  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned bytes_checked;
  int unsigned images_done;
  bit          quiet_tail;
  bit          hold_reader;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned code_bits();
    if (code_size_reg < 2) return 2;
    if (code_size_reg > 8) return 8;
    return code_size_reg;
  endfunction

  function automatic void wipe_dict();
    for (int i = 0; i < DICT_SIZE; i++) dict_used[i] = 1'b0;
    free_code = (1 << code_bits()) + 2;
    width_now = code_bits() + 1;
  endfunction

  function automatic void encoder_idle();
    img_open  = 1'b0;
    pend_code = 0;
    pack_buf  = '0;
    pack_fill = 0;
    wipe_dict();
  endfunction

  function automatic void emit_byte(logic [7:0] b);
    out_item_t r;
    r.out_byte   = b;
    r.final_byte = 1'b0;
    byte_queue.push_back(r);
    step_bytes++;
  endfunction

  function automatic void pack_code(int unsigned code, int unsigned bits);
    for (int i = 0; i < bits; i++) begin
      pack_buf[pack_fill] = 1'((code >> i) & 1);
      pack_fill++;
      if (pack_fill == 8) begin
        emit_byte(pack_buf);
        pack_buf  = '0;
        pack_fill = 0;
      end
    end
  endfunction

  // Work out the bytes one pixel request produces.
  function automatic void encode_pixel(in_item_t px);
    int unsigned clr, eoi, sym, c;
    bit hit;
    clr = 1 << code_bits();
    eoi = clr + 1;
    sym = px.pixel_index & (clr - 1);
    step_bytes = 0;
    if (!img_open) begin
      pack_code(clr, width_now);
      pend_code = sym;
      img_open  = 1'b1;
    end else begin
      hit = 1'b0;
      for (c = eoi + 1; c < free_code && c < DICT_SIZE; c++) begin
        if (dict_used[c] && dict_pfx[c] == pend_code && dict_sym[c] == sym) begin
          hit = 1'b1;
          break;
        end
      end
      if (hit) begin
        pend_code = c;
      end else begin
        if (free_code < DICT_SIZE) begin
          dict_used[free_code] = 1'b1;
          dict_pfx[free_code]  = 12'(pend_code);
          dict_sym[free_code]  = 8'(sym);
        end
        free_code++;
        pack_code(pend_code, width_now);
        pend_code = sym;
        if (free_code >= DICT_CAP) begin
          pack_code(clr, width_now);
          wipe_dict();
        end else if (free_code > (1 << width_now) && width_now < MAX_BITS) begin
          width_now++;
        end
      end
    end
    if (px.last_pixel) begin
      pack_code(pend_code, width_now);
      pack_code(eoi, width_now);
      if (pack_fill > 0) emit_byte(pack_buf);
      if (step_bytes > 0) byte_queue[$].final_byte = 1'b1;
      encoder_idle();
      images_done++;
    end
  endfunction

  // Hand one pixel request to the block; predict once it is accepted.
  task automatic send_pixel(logic [7:0] idx, logic lastp);
    in_item_t px;
    px.pixel_index = idx;
    px.last_pixel  = lastp;
    push    <= 1'b1;
    in_data <= px;
    do @(posedge clk); while (full);
    encode_pixel(px);
    // Random gap between requests; none in the closing stretch.
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (byte_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_code_size(logic [3:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    code_size_reg = v;
    encoder_idle();
  endtask

  // A short image of random pixels; indices may exceed the code size unless in_range is set.
  task automatic send_image(int unsigned len, bit in_range);
    logic [7:0] idx;
    for (int i = 0; i < len; i++) begin
      idx = $urandom_range(0, 255);
      if (in_range) idx = idx & 8'((1 << code_bits()) - 1);
      if ($urandom_range(0, 2) == 0) idx = idx & 8'h3;  // favor repeats
      send_pixel(idx, i == len - 1);
    end
  endtask

  // Receiver: pop at random, check each byte against the oldest prediction.
  initial begin
    out_item_t   want;
    int unsigned rd_idle;
    pop     = 1'b0;
    rd_idle = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        if (byte_queue.size() == 0) begin
          $error("byte popped with nothing predicted: %h", out_data.out_byte);
          error_count++;
        end else begin
          want = byte_queue.pop_front();
          if (out_data.out_byte !== want.out_byte) begin
            $error("out_byte expected %h actual %h", want.out_byte, out_data.out_byte);
            error_count++;
          end
          if (out_data.final_byte !== want.final_byte) begin
            $error("final_byte expected %b actual %b", want.final_byte,
                   out_data.final_byte);
            error_count++;
          end
          bytes_checked++;
        end
      end
      if (hold_reader) begin
        pop <= 1'b0;
      end else if (rd_idle > 0) begin
        pop <= 1'b0;
        rd_idle--;
      end else if (!quiet_tail && $urandom_range(0, 6) == 0) begin
        // idle burst: hold pop low and load a random idle count
        pop <= 1'b0;
        rd_idle = $urandom_range(0, 3);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Long receiver hold-off, counted here, so the block fills and stalls input.
  task automatic hold_off_reader(int unsigned cycles);
    hold_reader = 1'b1;
    repeat (cycles) @(posedge clk);
    hold_reader = 1'b0;
  endtask

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles", cycle_count);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Directed pixel table: extremes, single-pixel images and a repeat run.
  typedef struct {
    logic [7:0] idx;
    logic       lastp;
  } px_row_t;

  px_row_t directed [] = '{
    '{8'h00, 1'b1},  // single-pixel image
    '{8'hFF, 1'b1},
    '{8'h00, 1'b0}, '{8'h00, 1'b0}, '{8'h00, 1'b0}, '{8'h00, 1'b0},
    '{8'h00, 1'b0}, '{8'h00, 1'b1},
    '{8'hAA, 1'b0}, '{8'h55, 1'b0}, '{8'hAA, 1'b0}, '{8'h55, 1'b0},
    '{8'hAA, 1'b0}, '{8'h55, 1'b1},
    '{8'h01, 1'b0}, '{8'h02, 1'b0}, '{8'h80, 1'b0}, '{8'hFE, 1'b1}
  };

  initial begin
    error_count   = 0;
    bytes_checked = 0;
    images_done   = 0;
    quiet_tail    = 1'b0;
    hold_reader   = 1'b0;
    rst_n     <= 1'b0;
    push      <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    code_size_reg = 4'd8;
    encoder_idle();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset value first: a single zero pixel at code size 8 packs to
    // 00 01 04 04. Hold the reader so the prediction is still queued.
    hold_reader = 1'b1;
    send_pixel(8'h00, 1'b1);
    if (byte_queue.size() != 4 || byte_queue[0].out_byte != 8'h00 ||
        byte_queue[1].out_byte != 8'h01 || byte_queue[2].out_byte != 8'h04 ||
        byte_queue[3].out_byte != 8'h04 || !byte_queue[3].final_byte) begin
      $error("reset prediction off: clear, pixel 0 and end code at 9 bits");
      error_count++;
    end
    hold_reader = 1'b0;

    foreach (directed[i]) send_pixel(directed[i].idx, directed[i].lastp);

    // Clamped register values, then the narrowest setting.
    write_code_size(4'd0);
    send_image(6, 1'b0);
    write_code_size(4'd15);
    send_image(6, 1'b0);
    write_code_size(4'd2);
    send_pixel(8'hFF, 1'b1);
    send_image(10, 1'b0);

    // A longer image at the narrowest size, so the code width grows.
    send_image(40, 1'b1);

    // Back-pressure: stop the reader while requests keep coming.
    fork
      hold_off_reader(400);
      send_image(60, 1'b0);
    join
    // Sender pause until every predicted byte has been popped.
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      write_code_size(4'($urandom_range(2, 8)));
      for (int k = 0; k < 4; k++) send_image($urandom_range(1, 12), $urandom_range(0, 3) != 0);
    end
    write_code_size(4'd8);
    quiet_tail = 1'b1;
    for (int k = 0; k < 5; k++) send_image($urandom_range(1, 10), 1'b1);

    wait_drained();
    $display("Covered %0d images and %0d bytes across code sizes 0, 2..8 and 15,",
             images_done, bytes_checked);
    $display("including code width growth and a long reader stall.");
    if (error_count == 0 && byte_queue.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
